### src/nat_port_translation_top_defines.svh
// ---------------------------------------------------------------------------
// NAT port translation assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off in reset.
// ---------------------------------------------------------------------------
`ifndef NAT_PORT_TRANSLATION_TOP_DEFINES_SVH
`define NAT_PORT_TRANSLATION_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define NAT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed");

// trigger in this cycle implies the consequence in the same cycle
`define NAT_ASSERT_SAME(lbl, trig, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error("assertion failed");

// trigger in this cycle implies the consequence in the next cycle
`define NAT_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/nat_pkg.sv
// ---------------------------------------------------------------------------
// NAT port translation package
// Store sizes, port numbering, mode and status codes shared by the block.
// ---------------------------------------------------------------------------
package nat_pkg;

    localparam int MAP_ENTRIES  = 512;
    localparam int PEER_ENTRIES = 1024;

    localparam int MAP_AW  = $clog2(MAP_ENTRIES);
    localparam int PEER_AW = $clog2(PEER_ENTRIES);
    localparam int MAP_CW  = $clog2(MAP_ENTRIES + 1);
    localparam int PEER_CW = $clog2(PEER_ENTRIES + 1);
    localparam int SCAN_W  = (MAP_CW > PEER_CW) ? MAP_CW : PEER_CW;

    localparam int EP_W    = 48;
    localparam int ENTRY_W = 16 + EP_W;

    localparam int PORT_BASE   = 10000;
    localparam int PORT_STEP   = 100;
    localparam int PORT_LIMIT  = 50000;
    localparam int COUNT_LIMIT = (PORT_LIMIT - PORT_BASE) / PORT_STEP;

    localparam int PADDR_W = 3;
    localparam logic REG_NAT_MODE = 1'b0;

    localparam logic [2:0] MODE_NONE = 3'd0;
    localparam logic [2:0] MODE_FULL = 3'd1;
    localparam logic [2:0] MODE_ADDR = 3'd2;
    localparam logic [2:0] MODE_PORT = 3'd3;
    localparam logic [2:0] MODE_SYM  = 3'd4;

    localparam logic OP_OUT = 1'b0;
    localparam logic OP_IN  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_EXHAUST = 2'd2;
    localparam logic [1:0] STATUS_PEERFUL = 2'd3;

    typedef struct packed {
        logic [2:0] nat_mode;
    } nat_cfg_t;

    // external port of mapping slot idx
    function automatic logic [15:0] port_of(input logic [SCAN_W-1:0] idx);
        logic [31:0] p;
        p = 32'(PORT_BASE) + 32'(PORT_STEP) * (32'(idx) + 32'd1);
        return p[15:0];
    endfunction

endpackage

### src/nat_ram.sv
// ---------------------------------------------------------------------------
// NAT generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module nat_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/nat_cfg.sv
// ---------------------------------------------------------------------------
// NAT configuration register
// APB slave holding the translation mode.
// ---------------------------------------------------------------------------
module nat_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nat_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output nat_pkg::nat_cfg_t           cfg
);

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == nat_pkg::REG_NAT_MODE);

    always_comb begin
        mode_next = mode_reg;
        if (wr_hit) begin
            mode_next = pwdata[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= nat_pkg::MODE_NONE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    assign prdata = (paddr[2] == nat_pkg::REG_NAT_MODE) ? {29'd0, mode_reg} : 32'd0;
    assign cfg.nat_mode = mode_reg;

endmodule

### src/nat_port_translation_top.sv
// ---------------------------------------------------------------------------
// NAT port translation top level
// Mapping and peer stores in RAM, scanned entry by entry per item.
// ---------------------------------------------------------------------------
// channel   dir  handshake             contents
// s_        in   s_tvalid / s_tready   ports and remote endpoint, op in tuser
// m_        out  m_tvalid / m_tready   result port, status, new mapping flag
// apb       in   psel, penable, pready nat_mode at byte address 0
//
// Pass-through items skip the stores. In the other modes an item runs the
// mapping store scan and, in the restricted modes, the peer store scan, one
// entry per cycle through the single read port of each RAM, with a closing
// step after each scan.
// Reset is synchronous and immediate; the stores are tracked by fill counts.
// A new item is taken while the previous result waits in the output register.
// ---------------------------------------------------------------------------
`include "nat_port_translation_top_defines.svh"

module nat_port_translation_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [15:0] local_port, [31:16] external_port, [63:32] remote_addr,
    // [79:64] remote_port
    input  logic [79:0]                 s_tdata,
    // [0] operation
    input  logic [0:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] result_port, [17:16] status, [18] new_mapping, rest zero
    output logic [23:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nat_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PEER = 2'd1;
    localparam logic [1:0] ST_MAP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int SW = nat_pkg::SCAN_W;
    localparam int EW = nat_pkg::ENTRY_W;

    nat_pkg::nat_cfg_t cfg;

    logic [1:0]                 state_reg, state_next;
    logic                       op_reg, op_next;
    logic [2:0]                 mode_reg, mode_next;
    logic [15:0]                local_reg, local_next;
    logic [15:0]                ext_reg, ext_next;
    logic [nat_pkg::EP_W-1:0]   ep_reg, ep_next;
    logic [15:0]                key_reg, key_next;
    logic [SW-1:0]              idx_reg, idx_next;
    logic                       pend_reg, pend_next;
    logic [SW-1:0]              pidx_reg, pidx_next;
    logic [15:0]                rport_reg, rport_next;
    logic [1:0]                 rstat_reg, rstat_next;
    logic                       rnew_reg, rnew_next;
    logic [nat_pkg::MAP_CW-1:0] mcnt_reg, mcnt_next;
    logic [nat_pkg::PEER_CW-1:0] pcnt_reg, pcnt_next;
    logic                       ovld_reg, ovld_next;
    logic [23:0]                odata_reg, odata_next;

    logic          map_we, peer_we, map_re, peer_re;
    logic [EW-1:0] map_wdata, peer_wdata, map_rdata, peer_rdata;
    logic [SW-1:0] limit;
    logic          more, issue, restricted, addr_only, sym;
    logic          peer_hit, map_hit, hit, scan_end, accept, exhausted;

    nat_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nat_ram #(.DEPTH(nat_pkg::MAP_ENTRIES), .WIDTH(EW)) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (mcnt_reg[nat_pkg::MAP_AW-1:0]),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (idx_reg[nat_pkg::MAP_AW-1:0]),
        .rdata (map_rdata)
    );

    nat_ram #(.DEPTH(nat_pkg::PEER_ENTRIES), .WIDTH(EW)) u_peer_ram (
        .aclk  (aclk),
        .we    (peer_we),
        .waddr (pcnt_reg[nat_pkg::PEER_AW-1:0]),
        .wdata (peer_wdata),
        .re    (peer_re),
        .raddr (idx_reg[nat_pkg::PEER_AW-1:0]),
        .rdata (peer_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ovld_reg;
    assign m_tdata  = odata_reg;

    assign restricted = (mode_reg == nat_pkg::MODE_ADDR) || (mode_reg == nat_pkg::MODE_PORT);
    assign addr_only  = (mode_reg == nat_pkg::MODE_ADDR);
    assign sym        = (mode_reg == nat_pkg::MODE_SYM);

    assign limit = (state_reg == ST_PEER) ? SW'(pcnt_reg) : SW'(mcnt_reg);
    assign more  = (idx_reg < limit);

    assign peer_hit = pend_reg && (peer_rdata[63:48] == key_reg) &&
                      (addr_only ? (peer_rdata[47:16] == ep_reg[47:16])
                                 : (peer_rdata[47:0] == ep_reg));
    assign map_hit  = pend_reg &&
                      ((op_reg == nat_pkg::OP_OUT)
                        ? ((map_rdata[63:48] == local_reg) &&
                           (!sym || (map_rdata[47:0] == ep_reg)))
                        : (nat_pkg::port_of(pidx_reg) == ext_reg));
    assign hit      = (state_reg == ST_PEER) ? peer_hit : map_hit;
    assign scan_end = hit || (!pend_reg && !more);
    assign issue    = ((state_reg == ST_PEER) || (state_reg == ST_MAP)) && more && !hit;
    assign peer_re  = issue && (state_reg == ST_PEER);
    assign map_re   = issue && (state_reg == ST_MAP);

    assign exhausted = (32'(mcnt_reg) > 32'(nat_pkg::COUNT_LIMIT)) ||
                       (32'(mcnt_reg) >= 32'(nat_pkg::MAP_ENTRIES));

    assign peer_wdata = {local_reg, ep_reg};
    assign map_wdata  = {local_reg, (sym ? ep_reg : 48'd0)};

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        mode_next  = mode_reg;
        local_next = local_reg;
        ext_next   = ext_reg;
        ep_next    = ep_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        pidx_next  = idx_reg;
        rport_next = rport_reg;
        rstat_next = rstat_reg;
        rnew_next  = rnew_reg;
        mcnt_next  = mcnt_reg;
        pcnt_next  = pcnt_reg;
        ovld_next  = ovld_reg && !m_tready;
        odata_next = odata_reg;
        map_we     = 1'b0;
        peer_we    = 1'b0;

        if (issue) begin
            idx_next  = idx_reg + SW'(1);
            pend_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = s_tuser[0];
                    mode_next  = cfg.nat_mode;
                    local_next = s_tdata[15:0];
                    ext_next   = s_tdata[31:16];
                    ep_next    = {s_tdata[63:32], s_tdata[79:64]};
                    key_next   = s_tdata[15:0];
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    rnew_next  = 1'b0;
                    rstat_next = nat_pkg::STATUS_OK;
                    rport_next = s_tuser[0] ? s_tdata[31:16] : s_tdata[15:0];
                    if (!((cfg.nat_mode == nat_pkg::MODE_FULL) ||
                          (cfg.nat_mode == nat_pkg::MODE_ADDR) ||
                          (cfg.nat_mode == nat_pkg::MODE_PORT) ||
                          (cfg.nat_mode == nat_pkg::MODE_SYM))) begin
                        state_next = ST_DONE;
                    end else if ((s_tuser[0] == nat_pkg::OP_OUT) &&
                                 ((cfg.nat_mode == nat_pkg::MODE_ADDR) ||
                                  (cfg.nat_mode == nat_pkg::MODE_PORT))) begin
                        state_next = ST_PEER;
                    end else begin
                        state_next = ST_MAP;
                    end
                end
            end
            ST_PEER: begin
                if (scan_end) begin
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (op_reg == nat_pkg::OP_OUT) begin
                        if (hit) begin
                            state_next = ST_MAP;
                        end else if (32'(pcnt_reg) < 32'(nat_pkg::PEER_ENTRIES)) begin
                            // record the new peer in the next free slot
                            peer_we    = 1'b1;
                            pcnt_next  = pcnt_reg + nat_pkg::PEER_CW'(1);
                            state_next = ST_MAP;
                        end else begin
                            rport_next = '0;
                            rstat_next = nat_pkg::STATUS_PEERFUL;
                            state_next = ST_DONE;
                        end
                    end else begin
                        rport_next = hit ? key_reg : 16'd0;
                        rstat_next = hit ? nat_pkg::STATUS_OK : nat_pkg::STATUS_REFUSED;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MAP: begin
                if (scan_end) begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                    if (op_reg == nat_pkg::OP_OUT) begin
                        if (hit) begin
                            rport_next = nat_pkg::port_of(pidx_reg);
                        end else if (exhausted) begin
                            rport_next = '0;
                            rstat_next = nat_pkg::STATUS_EXHAUST;
                        end else begin
                            map_we     = 1'b1;
                            mcnt_next  = mcnt_reg + nat_pkg::MAP_CW'(1);
                            rport_next = nat_pkg::port_of(SW'(mcnt_reg));
                            rnew_next  = 1'b1;
                        end
                    end else if (!hit) begin
                        rport_next = '0;
                        rstat_next = nat_pkg::STATUS_REFUSED;
                    end else if (restricted) begin
                        // check the peer against the mapping's local port
                        key_next   = map_rdata[63:48];
                        state_next = ST_PEER;
                    end else begin
                        rport_next = map_rdata[63:48];
                    end
                end
            end
            ST_DONE: begin
                if (!ovld_reg || m_tready) begin
                    ovld_next  = 1'b1;
                    odata_next = {5'd0, rnew_reg, rstat_reg, rport_reg};
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
            mcnt_reg  <= '0;
            pcnt_reg  <= '0;
            ovld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            mcnt_reg  <= mcnt_next;
            pcnt_reg  <= pcnt_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        mode_reg  <= mode_next;
        local_reg <= local_next;
        ext_reg   <= ext_next;
        ep_reg    <= ep_next;
        key_reg   <= key_next;
        pidx_reg  <= pidx_next;
        rport_reg <= rport_next;
        rstat_reg <= rstat_next;
        rnew_reg  <= rnew_next;
        odata_reg <= odata_next;
    end

    `NAT_ASSERT_ALWAYS(a_map_cnt_cap, 32'(mcnt_reg) <= 32'(nat_pkg::COUNT_LIMIT + 1))
    `NAT_ASSERT_ALWAYS(a_peer_cnt_cap, 32'(pcnt_reg) <= 32'(nat_pkg::PEER_ENTRIES))
    `NAT_ASSERT_SAME(a_new_is_ok, m_tvalid && m_tdata[18], m_tdata[17:16] == nat_pkg::STATUS_OK)
    `NAT_ASSERT_SAME(a_fail_zero, m_tvalid && (m_tdata[17:16] != nat_pkg::STATUS_OK),
        m_tdata[15:0] == 16'd0)
    `NAT_ASSERT_NEXT(a_accept_busy, accept, !s_tready)

endmodule
